// File: src/pwtcd_pkg.sv
package pwtcd_pkg;

    localparam int SHIFT_BITS = 64;
    localparam int FRAME_BITS = 38;
    localparam int COUNT_BITS = 7;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 7'd127;

    localparam logic CMD_PULSE   = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    localparam logic [15:0] ZERO_MIN_RESET = 16'd2000;
    localparam logic [15:0] ZERO_MAX_RESET = 16'd4000;
    localparam logic [15:0] ONE_MAX_RESET  = 16'd7000;
    localparam logic [6:0]  MIN_BITS_RESET = 7'd58;

    localparam logic [2:0] WEEKDAY_WRAP = 3'd7;

    typedef enum logic [1:0] {
        REG_ZERO_MIN = 2'd0,
        REG_ZERO_MAX = 2'd1,
        REG_ONE_MAX  = 2'd2,
        REG_MIN_BITS = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] pulse_width;
    } item_t;

    typedef struct packed {
        logic       date_parity_ok;
        logic       hour_parity_ok;
        logic       minute_parity_ok;
        logic [7:0] year_value;
        logic [4:0] month_value;
        logic [2:0] weekday_value;
        logic [5:0] day_value;
        logic [5:0] hour_value;
        logic [6:0] minute_value;
    } result_t;

    typedef struct packed {
        logic [15:0] zero_min;
        logic [15:0] zero_max;
        logic [15:0] one_max;
        logic [6:0]  min_bits;
    } cfg_t;

    // Two BCD-style digits: tens * 10 + units, with no digit range check.
    function automatic logic [7:0] bcd_value(input logic [3:0] tens, input logic [3:0] units);
        logic [7:0] t8;
        logic [7:0] u8;
        begin
            t8 = {4'b0, tens};
            u8 = {4'b0, units};
            bcd_value = (t8 << 3) + (t8 << 1) + u8;
        end
    endfunction

endpackage

// File: src/pulse_width_time_code_decoder.sv
// A timeout transfer with at least min_bits bits is registered in the frame stage, then in the output register.
// Throughput: one item per cycle while item_stall is low; pulse items never produce a result.
// The frame stage and output register form a two-deep result path, so items keep
// flowing while one result waits; item_stall rises only when both are full and stalled.
// Reset clears the bit register, bit counter and valid flags and loads default thresholds.
module pulse_width_time_code_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  pwtcd_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output pwtcd_pkg::result_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    pwtcd_pkg::cfg_t    cfg;
    pwtcd_pkg::result_t decoded;

    logic [pwtcd_pkg::SHIFT_BITS-1:0] shift_reg;
    logic [pwtcd_pkg::SHIFT_BITS-1:0] shift_next;
    logic [pwtcd_pkg::COUNT_BITS-1:0] count_reg;
    logic [pwtcd_pkg::COUNT_BITS-1:0] count_next;
    logic                             frame_valid_reg;
    logic                             frame_valid_next;
    logic [pwtcd_pkg::FRAME_BITS-1:0] frame_reg;
    logic [pwtcd_pkg::FRAME_BITS-1:0] frame_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    pwtcd_pkg::result_t               out_reg;
    pwtcd_pkg::result_t               out_next;

    logic accept;
    logic frame_move;
    logic take_bit;
    logic bit_value;
    logic emit;

    pwtcd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pwtcd_decode u_decode (
        .frame  (frame_reg),
        .result (decoded)
    );

    assign frame_move   = !out_valid_reg || !result_stall;
    assign item_stall   = frame_valid_reg && !frame_move;
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign take_bit  = (item.pulse_width > cfg.zero_min)
                       && ((item.pulse_width < cfg.zero_max)
                           || (item.pulse_width < cfg.one_max));
    assign bit_value = !(item.pulse_width < cfg.zero_max);
    assign emit      = (count_reg >= cfg.min_bits);

    always_comb
    begin
        shift_next       = shift_reg;
        count_next       = count_reg;
        frame_next       = frame_reg;
        frame_valid_next = frame_valid_reg && !frame_move;
        out_valid_next   = out_valid_reg && result_stall;
        out_next         = out_reg;

        if (frame_valid_reg && frame_move)
        begin
            out_valid_next = 1'b1;
            out_next       = decoded;
        end

        if (accept)
        begin
            if (item.cmd == pwtcd_pkg::CMD_TIMEOUT)
            begin
                if (emit)
                begin
                    frame_valid_next = 1'b1;
                    frame_next       = shift_reg[pwtcd_pkg::FRAME_BITS-1:0];
                end
                shift_next = '0;
                count_next = '0;
            end
            else if (take_bit)
            begin
                shift_next = {shift_reg[pwtcd_pkg::SHIFT_BITS-2:0], bit_value};
                if (count_reg != pwtcd_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg       <= '0;
            count_reg       <= '0;
            frame_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            shift_reg       <= shift_next;
            count_reg       <= count_next;
            frame_valid_reg <= frame_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        out_reg   <= out_next;
    end

    a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.cmd == pwtcd_pkg::CMD_TIMEOUT |=> count_reg == '0 && shift_reg == '0)
        else $error("timeout transfer did not clear the bit state");

    a_pulse_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.cmd == pwtcd_pkg::CMD_PULSE |=> count_reg >= $past(count_reg))
        else $error("bit counter decreased on a pulse");

    a_result_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(frame_valid_reg))
        else $error("result appeared without a captured frame");

    a_frame_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_valid_reg ##1 frame_valid_reg |->
            $past(accept) && $past(item.cmd) == pwtcd_pkg::CMD_TIMEOUT && $past(emit))
        else $error("frame captured without a complete timeout");

endmodule

// File: src/pwtcd_cfg.sv
module pwtcd_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output pwtcd_pkg::cfg_t    cfg
);

    pwtcd_pkg::cfg_t      cfg_reg;
    pwtcd_pkg::cfg_t      cfg_next;
    pwtcd_pkg::reg_idx_t  idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = pwtcd_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                pwtcd_pkg::REG_ZERO_MIN: cfg_next.zero_min = pwdata[15:0];
                pwtcd_pkg::REG_ZERO_MAX: cfg_next.zero_max = pwdata[15:0];
                pwtcd_pkg::REG_ONE_MAX:  cfg_next.one_max  = pwdata[15:0];
                pwtcd_pkg::REG_MIN_BITS: cfg_next.min_bits = pwdata[6:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pwtcd_pkg::REG_ZERO_MIN: prdata = {16'b0, cfg_reg.zero_min};
            pwtcd_pkg::REG_ZERO_MAX: prdata = {16'b0, cfg_reg.zero_max};
            pwtcd_pkg::REG_ONE_MAX:  prdata = {16'b0, cfg_reg.one_max};
            pwtcd_pkg::REG_MIN_BITS: prdata = {25'b0, cfg_reg.min_bits};
            default:                 prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_min <= pwtcd_pkg::ZERO_MIN_RESET;
            cfg_reg.zero_max <= pwtcd_pkg::ZERO_MAX_RESET;
            cfg_reg.one_max  <= pwtcd_pkg::ONE_MAX_RESET;
            cfg_reg.min_bits <= pwtcd_pkg::MIN_BITS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/pwtcd_decode.sv
module pwtcd_decode (
    input  logic [pwtcd_pkg::FRAME_BITS-1:0] frame,
    output pwtcd_pkg::result_t               result
);

    logic [7:0] year_w;
    logic [7:0] month_w;
    logic [7:0] day_w;
    logic [7:0] hour_w;
    logic [7:0] minute_w;
    logic [2:0] wday_raw;

    // The last received bit of a field carries the largest weight.
    assign year_w   = pwtcd_pkg::bcd_value({frame[1], frame[2], frame[3], frame[4]},
                                           {frame[5], frame[6], frame[7], frame[8]});
    assign month_w  = pwtcd_pkg::bcd_value({3'b0, frame[9]},
                                           {frame[10], frame[11], frame[12], frame[13]});
    assign day_w    = pwtcd_pkg::bcd_value({2'b0, frame[17], frame[18]},
                                           {frame[19], frame[20], frame[21], frame[22]});
    assign hour_w   = pwtcd_pkg::bcd_value({2'b0, frame[24], frame[25]},
                                           {frame[26], frame[27], frame[28], frame[29]});
    assign minute_w = pwtcd_pkg::bcd_value({1'b0, frame[31], frame[32], frame[33]},
                                           {frame[34], frame[35], frame[36], frame[37]});
    assign wday_raw = {frame[14], frame[15], frame[16]};

    always_comb
    begin
        result.date_parity_ok   = ~^frame[22:0];
        result.hour_parity_ok   = ~^frame[29:23];
        result.minute_parity_ok = ~^frame[37:30];
        result.year_value       = year_w;
        result.month_value      = month_w[4:0];
        result.weekday_value    = (wday_raw == pwtcd_pkg::WEEKDAY_WRAP) ? 3'd0 : wday_raw;
        result.day_value        = day_w[5:0];
        result.hour_value       = hour_w[5:0];
        result.minute_value     = minute_w[6:0];
    end

endmodule

// File: test/pulse_width_time_code_decoder_tb.sv
module pulse_width_time_code_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum bit {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } fill_t;

    typedef struct packed {
        row_kind_t             kind;
        pwtcd_pkg::item_t      it;
        pwtcd_pkg::reg_idx_t   idx;
        logic [31:0]           value;
        bit                    typed;
        bit                    typed_emit;
        pwtcd_pkg::result_t    typed_res;
    } row_t;

    localparam pwtcd_pkg::result_t NO_RESULT   = '0;
    localparam pwtcd_pkg::result_t EMPTY_FRAME = {3'b111, 35'd0};

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    pwtcd_pkg::item_t   item;
    logic               result_valid;
    logic               result_stall;
    pwtcd_pkg::result_t result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    pwtcd_pkg::cfg_t    thresholds;
    logic [63:0]        frame_bits;
    logic [6:0]         frame_count;
    pwtcd_pkg::result_t expected_q[$];
    row_t               rows[$];

    int                 errors;
    int                 bits_and_timeouts;
    int                 items_sent;
    bit                 typed_row;
    bit                 typed_emit;
    pwtcd_pkg::result_t typed_res;
    bit                 hold_req;
    bit                 burst;
    bit                 emit_now;
    bit                 took_now;
    pwtcd_pkg::result_t predicted;
    pwtcd_pkg::result_t oldest;

    pulse_width_time_code_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic int bcd_sum(input logic [63:0] w, input int pos, input int n);
        int s;
        int i;
        int k;
        s = 0;
        for (i = 0; i < n; i++)
        begin
            k = n - 1 - i;
            if (w[pos + i])
                s += (k < 4) ? (1 << k) : (10 << (k - 4));
        end
        return s;
    endfunction

    function automatic void decode_item(input pwtcd_pkg::item_t it, output bit emit_o,
                                        output bit took_o, output pwtcd_pkg::result_t r);
        logic [63:0] w;
        logic [2:0]  wd;
        emit_o = 1'b0;
        took_o = 1'b0;
        r = NO_RESULT;
        if (it.cmd == pwtcd_pkg::CMD_PULSE)
        begin
            if (it.pulse_width > thresholds.zero_min)
            begin
                if (it.pulse_width < thresholds.zero_max)
                begin
                    took_o = 1'b1;
                    frame_bits = {frame_bits[62:0], 1'b0};
                end
                else if (it.pulse_width < thresholds.one_max)
                begin
                    took_o = 1'b1;
                    frame_bits = {frame_bits[62:0], 1'b1};
                end
            end
            if (took_o && frame_count != pwtcd_pkg::COUNT_MAX)
                frame_count = frame_count + 7'd1;
        end
        else
        begin
            w = frame_bits;
            if (frame_count >= thresholds.min_bits)
            begin
                emit_o = 1'b1;
                wd = 3'(bcd_sum(w, 14, 3));
                if (wd == pwtcd_pkg::WEEKDAY_WRAP)
                    wd = 3'd0;
                r.date_parity_ok   = ~^w[22:0];
                r.hour_parity_ok   = ~^w[29:23];
                r.minute_parity_ok = ~^w[37:30];
                r.year_value       = 8'(bcd_sum(w, 1, 8));
                r.month_value      = 5'(bcd_sum(w, 9, 5));
                r.weekday_value    = wd;
                r.day_value        = 6'(bcd_sum(w, 17, 6));
                r.hour_value       = 6'(bcd_sum(w, 24, 6));
                r.minute_value     = 7'(bcd_sum(w, 31, 7));
            end
            frame_bits = '0;
            frame_count = '0;
        end
    endfunction

    function automatic bit fields_match(input pwtcd_pkg::result_t a,
                                        input pwtcd_pkg::result_t b);
        return a.date_parity_ok === b.date_parity_ok && a.hour_parity_ok === b.hour_parity_ok
            && a.minute_parity_ok === b.minute_parity_ok && a.year_value === b.year_value
            && a.month_value === b.month_value && a.weekday_value === b.weekday_value
            && a.day_value === b.day_value && a.hour_value === b.hour_value
            && a.minute_value === b.minute_value;
    endfunction

    function automatic string fmt_result(input pwtcd_pkg::result_t r);
        return $sformatf("par=%b%b%b yr=%0d mo=%0d wd=%0d dy=%0d hr=%0d mi=%0d",
                         r.date_parity_ok, r.hour_parity_ok, r.minute_parity_ok, r.year_value,
                         r.month_value, r.weekday_value, r.day_value, r.hour_value,
                         r.minute_value);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                decode_item(item, emit_now, took_now, predicted);
                if (took_now || item.cmd == pwtcd_pkg::CMD_TIMEOUT)
                    bits_and_timeouts++;
                if (typed_row)
                begin
                    emit_now = typed_emit;
                    predicted = typed_res;
                end
                if (emit_now)
                    expected_q.push_back(predicted);
            end
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: %s", fmt_result(result));
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    if (!fields_match(oldest, result))
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("result mismatch: expected %s, got %s",
                                     fmt_result(oldest), fmt_result(result));
                    end
                end
            end
        end
    end

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [15:0] width_for(input bit b);
        int lo;
        int hi;
        int pick;
        if (!b)
        begin
            lo = int'(thresholds.zero_min) + 1;
            hi = int'(thresholds.zero_max) - 1;
        end
        else
        begin
            lo = int'(thresholds.zero_min) + 1;
            if (int'(thresholds.zero_max) > lo)
                lo = int'(thresholds.zero_max);
            hi = int'(thresholds.one_max) - 1;
        end
        if (lo > hi)
            return 16'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'(lo);
        if (pick == 1)
            return 16'(hi);
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [15:0] noise_width();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return thresholds.zero_min;
            2: return thresholds.one_max;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input pwtcd_pkg::item_t it);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        items_sent++;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(input int nbits, input fill_t fill);
        pwtcd_pkg::item_t it;
        int               i;
        bit               b;
        for (i = 0; i < nbits; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                it.cmd = pwtcd_pkg::CMD_PULSE;
                it.pulse_width = noise_width();
                send_item(it);
            end
            case (fill)
                FILL_ONES: b = 1'b1;
                FILL_ZEROS: b = 1'b0;
                default: b = $urandom_range(0, 1);
            endcase
            it.cmd = pwtcd_pkg::CMD_PULSE;
            it.pulse_width = width_for(b);
            send_item(it);
        end
        it.cmd = pwtcd_pkg::CMD_TIMEOUT;
        it.pulse_width = 16'($urandom);
        send_item(it);
    endtask

    task automatic wait_drain();
        item_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input pwtcd_pkg::reg_idx_t idx, input int v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            pwtcd_pkg::REG_ZERO_MIN: thresholds.zero_min = v[15:0];
            pwtcd_pkg::REG_ZERO_MAX: thresholds.zero_max = v[15:0];
            pwtcd_pkg::REG_ONE_MAX: thresholds.one_max = v[15:0];
            default: thresholds.min_bits = v[6:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic add_item(input logic cmd, input int w, input bit typed, input bit em,
                            input pwtcd_pkg::result_t res);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.it.cmd = cmd;
        r.it.pulse_width = 16'(w);
        r.typed = typed;
        r.typed_emit = em;
        r.typed_res = res;
        rows.push_back(r);
    endtask

    task automatic add_cfg(input pwtcd_pkg::reg_idx_t idx, input int v);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.value = v;
        rows.push_back(r);
    endtask

    initial
    begin : receiver
        int left;
        int cyc;
        int r;
        left = 0;
        cyc = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (60) @(negedge clk);
                hold_req = 1'b0;
                result_stall <= 1'b0;
            end
            else if (left > 0)
            begin
                left--;
                result_stall <= 1'b1;
            end
            else if ((cyc / 300) % 3 == 0)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    left = $urandom_range(10, 40);
                    result_stall <= 1'b1;
                end
                else if (r < 30)
                begin
                    left = $urandom_range(0, 2);
                    result_stall <= 1'b1;
                end
                else
                begin
                    result_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        #12_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        pwtcd_pkg::item_t it;
        int               zmin;
        int               zmax;
        int               omax;
        int               mb;
        int               budget;
        int               start_useful;
        int               sent_start;
        int               phase;
        int               pick;
        fill_t            fill;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        typed_row = 1'b0;
        typed_emit = 1'b0;
        typed_res = NO_RESULT;
        hold_req = 1'b0;
        burst = 1'b0;
        errors = 0;
        bits_and_timeouts = 0;
        items_sent = 0;
        thresholds = {pwtcd_pkg::ZERO_MIN_RESET, pwtcd_pkg::ZERO_MAX_RESET,
                      pwtcd_pkg::ONE_MAX_RESET, pwtcd_pkg::MIN_BITS_RESET};
        frame_bits = '0;
        frame_count = '0;

        add_item(pwtcd_pkg::CMD_TIMEOUT, 0, 1, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_PULSE, 0, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_PULSE, 2000, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_PULSE, 2001, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_PULSE, 3999, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_PULSE, 4000, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_PULSE, 6999, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_PULSE, 7000, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_PULSE, 65535, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_TIMEOUT, 65535, 1, 0, NO_RESULT);
        add_cfg(pwtcd_pkg::REG_MIN_BITS, 0);
        add_item(pwtcd_pkg::CMD_TIMEOUT, 0, 1, 1, EMPTY_FRAME);
        add_item(pwtcd_pkg::CMD_PULSE, 4000, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_TIMEOUT, 0, 0, 0, NO_RESULT);
        add_cfg(pwtcd_pkg::REG_ZERO_MIN, 5000);
        add_cfg(pwtcd_pkg::REG_ZERO_MAX, 3000);
        add_cfg(pwtcd_pkg::REG_ONE_MAX, 6000);
        add_item(pwtcd_pkg::CMD_PULSE, 4000, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_PULSE, 5500, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_PULSE, 5001, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_PULSE, 6000, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_TIMEOUT, 0, 0, 0, NO_RESULT);
        add_cfg(pwtcd_pkg::REG_MIN_BITS, 127);
        add_item(pwtcd_pkg::CMD_PULSE, 5500, 0, 0, NO_RESULT);
        add_item(pwtcd_pkg::CMD_TIMEOUT, 0, 1, 0, NO_RESULT);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                wait_drain();
                cfg_write(rows[i].idx, int'(rows[i].value));
            end
            else
            begin
                typed_row = rows[i].typed;
                typed_emit = rows[i].typed_emit;
                typed_res = rows[i].typed_res;
                send_item(rows[i].it);
            end
        end
        typed_row = 1'b0;

        phase = 0;
        while (items_sent < 1100 && phase < 60)
        begin
            case (phase)
                0:
                begin
                    zmin = 2000; zmax = 4000; omax = 7000; mb = 58;
                end
                1:
                begin
                    zmin = 0; zmax = 32768; omax = 65535; mb = 64;
                end
                2:
                begin
                    zmin = 65535; zmax = 0; omax = 0; mb = 0;
                end
                3:
                begin
                    zmin = 2000; zmax = 4000; omax = 7000; mb = 127;
                end
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        zmin = $urandom_range(0, 65535);
                        zmax = $urandom_range(0, 65535);
                        omax = $urandom_range(0, 65535);
                        mb = $urandom_range(0, 5);
                    end
                    else
                    begin
                        zmin = $urandom_range(0, 20000);
                        zmax = zmin + $urandom_range(2, 20000);
                        omax = zmax + $urandom_range(1, 20000);
                        mb = $urandom_range(0, 64);
                    end
                end
            endcase
            wait_drain();
            cfg_write(pwtcd_pkg::REG_ZERO_MIN, zmin);
            cfg_write(pwtcd_pkg::REG_ZERO_MAX, zmax);
            cfg_write(pwtcd_pkg::REG_ONE_MAX, omax);
            cfg_write(pwtcd_pkg::REG_MIN_BITS, mb);
            budget = (phase == 2 || phase == 3) ? 60 : 200;
            start_useful = bits_and_timeouts;
            sent_start = items_sent;

            // Results pile up behind a long output stall until the input side backs up.
            if (phase == 2)
            begin
                hold_req = 1'b1;
                burst = 1'b1;
                repeat (30)
                begin
                    it.cmd = pwtcd_pkg::CMD_TIMEOUT;
                    it.pulse_width = 16'($urandom);
                    send_item(it);
                end
            end

            while (bits_and_timeouts - start_useful < budget && items_sent - sent_start < 2000
                   && items_sent < 1100)
            begin
                burst = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    case ($urandom_range(0, 9))
                        0: fill = FILL_ONES;
                        1: fill = FILL_ZEROS;
                        default: fill = FILL_RANDOM;
                    endcase
                    send_frame(int'(thresholds.min_bits) + $urandom_range(0, 5), fill);
                end
                else if (pick < 82)
                begin
                    send_frame($urandom_range(0, int'(thresholds.min_bits)), FILL_RANDOM);
                end
                else if (pick < 86)
                begin
                    send_frame($urandom_range(128, 135), FILL_RANDOM);
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        it.cmd = ($urandom_range(0, 4) == 0) ? pwtcd_pkg::CMD_TIMEOUT
                                                            : pwtcd_pkg::CMD_PULSE;
                        it.pulse_width = noise_width();
                        send_item(it);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    wait_drain();
            end
            phase++;
        end

        wait_drain();
        repeat (8) @(negedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: pulse_width_time_code_decoder.f
src/pwtcd_pkg.sv
src/pwtcd_cfg.sv
src/pwtcd_decode.sv
src/pulse_width_time_code_decoder.sv
test/pulse_width_time_code_decoder_tb.sv
